// ----- sv/bbd_pkg.sv -----
package bbd_pkg;

  localparam int MAX_LINE_DEF = 1024;
  localparam int PIX_W        = 8;
  // Wide enough for every position, size and window edge compare.
  localparam int EXT_W        = 13;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 12;

  localparam int SW_W = 11;
  localparam int SH_W = 12;
  localparam int XO_W = 10;
  localparam int YO_W = 12;
  localparam int CW_W = 11;
  localparam int CH_W = 12;

  localparam logic [SW_W-1:0] SW_RST = SW_W'(640);
  localparam logic [SH_W-1:0] SH_RST = SH_W'(480);
  localparam logic [XO_W-1:0] XO_RST = '0;
  localparam logic [YO_W-1:0] YO_RST = '0;
  localparam logic [CW_W-1:0] CW_RST = CW_W'(640);
  localparam logic [CH_W-1:0] CH_RST = CH_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_CROP_X     = 3'd2,
    REG_CROP_Y     = 3'd3,
    REG_CROP_W     = 3'd4,
    REG_CROP_H     = 3'd5
  } cfg_reg_t;

  // Per-request control that travels with a pixel into the interpolation stage.
  typedef struct packed {
    logic produce;
    logic left_edge;
    logic right_edge;
    logic top_edge;
    logic bot_edge;
    logic cx_odd;
    logic cy_odd;
    logic last;
  } pix_info_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             last;
  } rgb_t;

endpackage

// ----- sv/bbd_line_store.sv -----
module bbd_line_store #(
  parameter int MAX_LINE = bbd_pkg::MAX_LINE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_LINE)-1:0]  rd_addr,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_LINE)-1:0]  wr_addr,
  input  logic [2*bbd_pkg::PIX_W-1:0]  wr_data,
  output logic [2*bbd_pkg::PIX_W-1:0]  rd_data
);

  localparam int DW = 2 * bbd_pkg::PIX_W;

  // Each entry holds {row above, middle row} for one column.
  logic [DW-1:0] mem [MAX_LINE];
  logic [DW-1:0] q_r;
  logic [DW-1:0] fwd_data_r;
  logic          fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
    fwd_data_r <= wr_data;
  end

  // A read that meets the write-back of the same column in the same cycle
  // takes the fresh data instead of the stale memory word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (rd_addr == wr_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : q_r;

endmodule

// ----- sv/bbd_pixel_calc.sv -----
module bbd_pixel_calc (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid,
  input  bbd_pkg::pix_info_t          info,
  input  logic [bbd_pkg::PIX_W-1:0]   pix_above,
  input  logic [bbd_pkg::PIX_W-1:0]   pix_middle,
  input  logic [bbd_pkg::PIX_W-1:0]   pix_new,
  output logic                        res_valid,
  output bbd_pkg::rgb_t               res
);

  localparam int PW = bbd_pkg::PIX_W;
  localparam int SW = PW + 2;

  logic [PW-1:0] win_r [3][3];
  logic [PW-1:0] new_col [3];
  logic [PW-1:0] lcol [3];
  logic [PW-1:0] ccol [3];
  logic [PW-1:0] rcol [3];
  logic [PW-1:0] ctr, lf, rg, up, dn, lt, rt, lb, rb;
  logic [SW-1:0] diag_sum, orth_sum;
  logic [SW-1:0] ud_sum, lr_sum;
  logic [PW-1:0] diag, orth, ud, lr;

  assign new_col[0] = pix_above;
  assign new_col[1] = pix_middle;
  assign new_col[2] = pix_new;

  // Window column 2 is the pixel's own column; the left and right neighbors
  // fold back onto it at the frame edge.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ccol[i] = win_r[i][2];
      lcol[i] = info.left_edge ? win_r[i][2] : win_r[i][1];
      rcol[i] = info.right_edge ? win_r[i][2] : new_col[i];
    end
  end

  always_comb begin
    ctr = ccol[1];
    lf  = lcol[1];
    rg  = rcol[1];
    up  = info.top_edge ? ccol[1] : ccol[0];
    dn  = info.bot_edge ? ccol[1] : ccol[2];
    lt  = info.top_edge ? lcol[1] : lcol[0];
    rt  = info.top_edge ? rcol[1] : rcol[0];
    lb  = info.bot_edge ? lcol[1] : lcol[2];
    rb  = info.bot_edge ? rcol[1] : rcol[2];
    diag_sum = SW'(lt) + SW'(rt) + SW'(lb) + SW'(rb);
    orth_sum = SW'(lf) + SW'(rg) + SW'(up) + SW'(dn);
    ud_sum   = SW'(up) + SW'(dn);
    lr_sum   = SW'(lf) + SW'(rg);
    diag     = diag_sum[SW-1:2];
    orth     = orth_sum[SW-1:2];
    ud       = ud_sum[PW:1];
    lr       = lr_sum[PW:1];
  end

  always_comb begin
    res.last = info.last;
    case ({info.cy_odd, info.cx_odd})
      2'b00: begin
        res.red = diag; res.green = orth; res.blue = ctr;
      end
      2'b01: begin
        res.red = ud; res.green = ctr; res.blue = lr;
      end
      2'b10: begin
        res.red = lr; res.green = ctr; res.blue = ud;
      end
      default: begin
        res.red = ctr; res.green = orth; res.blue = diag;
      end
    endcase
  end

  assign res_valid = valid && info.produce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (valid) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
        win_r[i][2] <= new_col[i];
      end
    end
  end

endmodule

// ----- sv/bbd_out_queue.sv -----
module bbd_out_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bbd_pkg::rgb_t push_data,
  input  logic          pop,
  output logic          head_valid,
  output bbd_pkg::rgb_t head_data,
  output logic [1:0]    count
);

  bbd_pkg::rgb_t entry_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = entry_r[rd_ptr_r];
  assign count      = cnt_r;

endmodule

// ----- sv/bayer_bilinear_demosaic_crop.sv -----
// Bilinear demosaic of a BGGR Bayer stream with a crop window.
// Raw samples enter in raster order on the in_ channel (valid/ready), one
// per cycle while in_ready is high. A pixel's RGB result leaves on the out_
// channel once its 3x3 neighborhood is in, which is source_width+1 requests
// after the pixel; after the frame, source_width+1 requests with in_pad set
// drain the last row. Only pixels inside the crop window give a result;
// out_last marks the bottom-right pixel of the clipped window.
// Throughput is one request per cycle while in_ready is high. The request's
// line-store read and fields are registered into the interpolation stage,
// whose result lands in a two-entry output queue that drives out_.
// The two line stores share one memory that is read and written once per
// request; a back-to-back access of the same column is forwarded.
// When the receiver stalls, in_ready falls once the output queue and the
// request in flight would fill it, and no result is lost.
// The user must write registers through cfg_we/cfg_index/cfg_data only while
// the block is idle; the block does not enforce this. Each write to a defined
// register restarts the frame. Synchronous reset restores the register defaults
// (640x480, full crop) and empties the pipeline, with no memory clearing pass.
module bayer_bilinear_demosaic_crop #(
  parameter int MAX_LINE = bbd_pkg::MAX_LINE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bbd_pkg::PIX_W-1:0]         in_raw_pixel,
  input  logic                              in_pad,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bbd_pkg::PIX_W-1:0]         out_red,
  output logic [bbd_pkg::PIX_W-1:0]         out_green,
  output logic [bbd_pkg::PIX_W-1:0]         out_blue,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [bbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bbd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = $clog2(MAX_LINE);
  localparam int EW = bbd_pkg::EXT_W;
  localparam int PW = bbd_pkg::PIX_W;

  // Configuration registers.
  logic [bbd_pkg::SW_W-1:0] src_width_r;
  logic [bbd_pkg::SH_W-1:0] src_height_r;
  logic [bbd_pkg::XO_W-1:0] crop_x_r;
  logic [bbd_pkg::YO_W-1:0] crop_y_r;
  logic [bbd_pkg::CW_W-1:0] crop_w_r;
  logic [bbd_pkg::CH_W-1:0] crop_h_r;
  logic                     cfg_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= bbd_pkg::SW_RST;
      src_height_r <= bbd_pkg::SH_RST;
      crop_x_r     <= bbd_pkg::XO_RST;
      crop_y_r     <= bbd_pkg::YO_RST;
      crop_w_r     <= bbd_pkg::CW_RST;
      crop_h_r     <= bbd_pkg::CH_RST;
    end else if (cfg_we) begin
      unique case (bbd_pkg::cfg_reg_t'(cfg_index))
        bbd_pkg::REG_SRC_WIDTH:  src_width_r  <= cfg_data[bbd_pkg::SW_W-1:0];
        bbd_pkg::REG_SRC_HEIGHT: src_height_r <= cfg_data[bbd_pkg::SH_W-1:0];
        bbd_pkg::REG_CROP_X:     crop_x_r     <= cfg_data[bbd_pkg::XO_W-1:0];
        bbd_pkg::REG_CROP_Y:     crop_y_r     <= cfg_data[bbd_pkg::YO_W-1:0];
        bbd_pkg::REG_CROP_W:     crop_w_r     <= cfg_data[bbd_pkg::CW_W-1:0];
        bbd_pkg::REG_CROP_H:     crop_h_r     <= cfg_data[bbd_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (bbd_pkg::cfg_reg_t'(cfg_index)) inside
      bbd_pkg::REG_SRC_WIDTH, bbd_pkg::REG_SRC_HEIGHT, bbd_pkg::REG_CROP_X,
      bbd_pkg::REG_CROP_Y, bbd_pkg::REG_CROP_W, bbd_pkg::REG_CROP_H:
        cfg_hit = cfg_we;
      default: cfg_hit = 1'b0;
    endcase
  end

  // Effective frame size and clipped crop end.
  logic [EW-1:0] w_eff, h_eff, x_end, y_end, x_sum, y_sum;

  always_comb begin
    if (src_width_r == '0) begin
      w_eff = EW'(1);
    end else if (EW'(src_width_r) > EW'(MAX_LINE)) begin
      w_eff = EW'(MAX_LINE);
    end else begin
      w_eff = EW'(src_width_r);
    end
    h_eff = (src_height_r == '0) ? EW'(1) : EW'(src_height_r);
    x_sum = EW'(crop_x_r) + EW'(crop_w_r);
    y_sum = EW'(crop_y_r) + EW'(crop_h_r);
    x_end = (x_sum > w_eff) ? w_eff : x_sum;
    y_end = (y_sum > h_eff) ? h_eff : y_sum;
  end

  // Position counters and request decode.
  logic [AW-1:0] col_r, col_nxt;
  logic [EW-1:0] row_r, row_nxt;
  logic [EW-1:0] col_ext, col_inc, cx, cy;
  logic          accept;
  logic          p_edge, p_mid, in_x, in_y;
  logic [PW-1:0] pix;
  bbd_pkg::pix_info_t info;

  assign accept  = in_valid && in_ready;
  assign col_ext = EW'(col_r);
  assign col_inc = col_ext + EW'(1);
  assign pix     = in_pad ? '0 : in_raw_pixel;

  always_comb begin
    // At a row start the pending pixel is the last column two rows up.
    p_edge = (col_r == '0) && (row_r >= EW'(2));
    p_mid  = (col_r != '0) && (row_r >= EW'(1)) && (row_r <= h_eff);
    cx     = p_edge ? (w_eff - EW'(1)) : (col_ext - EW'(1));
    cy     = p_edge ? (row_r - EW'(2)) : (row_r - EW'(1));
    in_x   = (cx >= EW'(crop_x_r)) && ((cx - EW'(crop_x_r)) < EW'(crop_w_r));
    in_y   = (cy >= EW'(crop_y_r)) && ((cy - EW'(crop_y_r)) < EW'(crop_h_r));
    info.produce    = (p_edge || p_mid) && in_x && in_y;
    info.left_edge  = (cx == '0);
    info.right_edge = ((cx + EW'(1)) >= w_eff);
    info.top_edge   = (cy == '0);
    info.bot_edge   = ((cy + EW'(1)) >= h_eff);
    info.cx_odd     = cx[0];
    info.cy_odd     = cy[0];
    info.last       = ((cx + EW'(1)) == x_end) && ((cy + EW'(1)) == y_end);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if ((col_r == '0) && (row_r >= (h_eff + EW'(1)))) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = row_r + EW'(1);
      end else begin
        col_nxt = col_inc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Interpolation stage registers.
  logic               s1_v_r;
  logic [AW-1:0]      s1_addr_r;
  logic [PW-1:0]      s1_pix_r;
  bbd_pkg::pix_info_t s1_info_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r <= col_r;
      s1_pix_r  <= pix;
      s1_info_r <= info;
    end
  end

  logic [2*PW-1:0] line_q;

  bbd_line_store #(
    .MAX_LINE (MAX_LINE)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (col_r),
    .wr_en   (s1_v_r),
    .wr_addr (s1_addr_r),
    .wr_data ({line_q[PW-1:0], s1_pix_r}),
    .rd_data (line_q)
  );

  logic          res_valid;
  bbd_pkg::rgb_t res;

  bbd_pixel_calc u_pixel_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid      (s1_v_r),
    .info       (s1_info_r),
    .pix_above  (line_q[2*PW-1:PW]),
    .pix_middle (line_q[PW-1:0]),
    .pix_new    (s1_pix_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Output queue.
  logic          pop;
  logic [1:0]    q_count;
  logic [1:0]    occ;
  bbd_pkg::rgb_t head;

  assign pop = out_valid && out_ready;

  bbd_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .pop        (pop),
    .head_valid (out_valid),
    .head_data  (head),
    .count      (q_count)
  );

  // Room must remain for the request already in the interpolation stage.
  assign occ      = q_count - 2'(pop) + 2'(s1_v_r);
  assign in_ready = (occ < 2'd2);

  assign out_red   = head.red;
  assign out_green = head.green;
  assign out_blue  = head.blue;
  assign out_last  = head.last;

endmodule
